// ===== design/uite_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uite_pkg
// shared types, codes and helpers of the uart interrupt transfer engine
// ----------------------------------------------------------------------------
package uite_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int POS_W          = 16;
  localparam int BYTE_W         = 9;
  localparam int IN_DATA_W      = 56;
  localparam int OUT_DATA_W     = 72;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [2:0] MODE_START_TX = 3'd0;
  localparam logic [2:0] MODE_START_RX = 3'd1;
  localparam logic [2:0] MODE_EVENT    = 3'd2;
  localparam logic [2:0] MODE_KILL_TX  = 3'd3;
  localparam logic [2:0] MODE_KILL_RX  = 3'd4;
  localparam logic [2:0] MODE_CLEAR    = 3'd5;

  localparam logic [1:0] REPLY_OK      = 2'd0;
  localparam logic [1:0] REPLY_BUSY    = 2'd1;
  localparam logic [1:0] REPLY_INVALID = 2'd2;

  localparam logic [1:0] TXS_IDLE     = 2'd0;
  localparam logic [1:0] TXS_ONGOING  = 2'd1;
  localparam logic [1:0] TXS_COMPLETE = 2'd2;
  localparam logic [1:0] RXS_IDLE     = 2'd0;
  localparam logic [1:0] RXS_ONGOING  = 2'd1;
  localparam logic [1:0] RXS_COMPLETE = 2'd2;
  localparam logic [1:0] RXS_ABORTED  = 2'd3;

  // enable bit positions
  localparam int EN_TE     = 0;
  localparam int EN_RE     = 1;
  localparam int EN_TXEIE  = 2;
  localparam int EN_TCIE   = 3;
  localparam int EN_RXNEIE = 4;
  localparam int EN_IDLEIE = 5;

  // status snapshot bit positions
  localparam int ST_IDLE = 4;
  localparam int ST_RXNE = 5;
  localparam int ST_TC   = 6;
  localparam int ST_TXE  = 7;

  localparam int FL_IDLE_ABORT = 4;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WAKE_ENABLE = 3'd0;

  typedef enum logic [2:0] {
    TX_IDLE   = 3'b001,
    TX_ACTIVE = 3'b010,
    TX_DONE   = 3'b100
  } tx_phase_t;

  typedef enum logic [3:0] {
    RX_IDLE   = 4'b0001,
    RX_ACTIVE = 4'b0010,
    RX_DONE   = 4'b0100,
    RX_ABORT  = 4'b1000
  } rx_phase_t;

  typedef struct packed {
    logic [4:0]        clear_mask;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] tx_byte;
    logic [15:0]       length;
    logic [7:0]        status_flags;
    logic [2:0]        mode;
  } item_t;

  typedef struct packed {
    logic              wake;
    logic [4:0]        runtime_flags;
    logic [5:0]        control_bits;
    logic [1:0]        rx_status;
    logic [1:0]        tx_status;
    logic [POS_W-1:0]  next_tx_offset;
    logic [POS_W-1:0]  rx_store_offset;
    logic [BYTE_W-1:0] rx_store_data;
    logic              rx_store;
    logic [BYTE_W-1:0] dr_write_data;
    logic              dr_write;
    logic [1:0]        reply;
  } result_t;

  typedef struct packed {
    tx_phase_t        tx_phase;
    rx_phase_t        rx_phase;
    logic [POS_W-1:0] tx_pos;
    logic [POS_W-1:0] rx_pos;
    logic [5:0]       enables;
    logic [4:0]       sticky;
  } ctl_state_t;

  function automatic logic [1:0] tx_code(input tx_phase_t ph);
    logic [1:0] c;
    unique case (ph)
      TX_IDLE:   c = TXS_IDLE;
      TX_ACTIVE: c = TXS_ONGOING;
      TX_DONE:   c = TXS_COMPLETE;
      default:   c = TXS_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] rx_code(input rx_phase_t ph);
    logic [1:0] c;
    unique case (ph)
      RX_IDLE:   c = RXS_IDLE;
      RX_ACTIVE: c = RXS_ONGOING;
      RX_DONE:   c = RXS_COMPLETE;
      RX_ABORT:  c = RXS_ABORTED;
      default:   c = RXS_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/uart_interrupt_transfer_engine.sv =====
`default_nettype none
// a word accepted into the input register has its result registered in the
// result register once the word advances; a result not taken holds it back
// throughput: one word per cycle, limited by the input and result registers,
// while results are taken; the transfer state is updated in the same cycle
// the result is registered; reset (synchronous, active low) clears both stages,
// all transfer state and the wake enable
// ----------------------------------------------------------------------------
// uart_interrupt_transfer_engine
// counted uart transmit/receive controller driven by interrupt snapshots
// ----------------------------------------------------------------------------
module uart_interrupt_transfer_engine #(
  parameter int COUNT_BITS = uite_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // mode[2:0] status_flags[10:3] length[26:11] tx_byte[35:27] rx_byte[44:36]
  // clear_mask[49:45], zero fill above
  input  wire logic [uite_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // reply[1:0] dr_write[2] dr_write_data[11:3] rx_store[12] rx_store_data[21:13]
  // rx_store_offset[37:22] next_tx_offset[53:38] tx_status[55:54]
  // rx_status[57:56] control_bits[63:58] runtime_flags[68:64] wake[69]
  output logic      [uite_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [uite_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [uite_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [uite_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import uite_pkg::*;

  logic                  wake_enable;
  item_t                 item_r;
  logic                  item_v_r;
  result_t               res_r;
  result_t               res_nxt;
  logic                  res_v_r;
  ctl_state_t            st_r;
  ctl_state_t            st_nxt;
  logic [COUNT_BITS-1:0] tx_left_r;
  logic [COUNT_BITS-1:0] tx_left_nxt;
  logic [COUNT_BITS-1:0] rx_left_r;
  logic [COUNT_BITS-1:0] rx_left_nxt;
  logic                  advance;

  uite_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .wake_enable (wake_enable)
  );

  uite_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .item        (item_r),
    .cur         (st_r),
    .tx_left     (tx_left_r),
    .rx_left     (rx_left_r),
    .wake_enable (wake_enable),
    .nxt         (st_nxt),
    .tx_left_nxt (tx_left_nxt),
    .rx_left_nxt (rx_left_nxt),
    .res         (res_nxt)
  );

  assign advance    = item_v_r && (!res_v_r || out_tready);
  assign in_tready  = !item_v_r || advance;
  assign out_tvalid = res_v_r;
  assign out_tdata  = {2'b00, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r   <= 1'b0;
      st_r      <= '{tx_phase: TX_IDLE, rx_phase: RX_IDLE, tx_pos: '0, rx_pos: '0,
                     enables: '0, sticky: '0};
      tx_left_r <= '0;
      rx_left_r <= '0;
    end else if (advance) begin
      res_v_r   <= 1'b1;
      st_r      <= st_nxt;
      tx_left_r <= tx_left_nxt;
      rx_left_r <= rx_left_nxt;
    end else if (out_tready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/uite_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uite_cfg
// apb-style register port holding the wake enable
// ----------------------------------------------------------------------------
module uite_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [uite_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [uite_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [uite_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready,
  output logic                                 wake_enable
);
  import uite_pkg::*;

  logic wake_enable_r;
  logic hit;

  // word-aligned register decode
  assign hit        = (cfg_paddr[CFG_ADDR_W-1:2] == ADDR_WAKE_ENABLE[CFG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wake_enable = wake_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_enable_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && hit) begin
      wake_enable_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (hit) begin
      cfg_prdata[0] = wake_enable_r;
    end
  end

endmodule
`default_nettype wire

// ===== design/uite_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uite_step
// next-state and result logic for one transfer control word
// ----------------------------------------------------------------------------
module uite_step #(
  parameter int COUNT_BITS = uite_pkg::COUNT_BITS_DEF
) (
  input  wire uite_pkg::item_t      item,
  input  wire uite_pkg::ctl_state_t cur,
  input  wire logic [COUNT_BITS-1:0] tx_left,
  input  wire logic [COUNT_BITS-1:0] rx_left,
  input  wire logic                 wake_enable,
  output uite_pkg::ctl_state_t      nxt,
  output logic [COUNT_BITS-1:0]     tx_left_nxt,
  output logic [COUNT_BITS-1:0]     rx_left_nxt,
  output uite_pkg::result_t         res
);
  import uite_pkg::*;

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  logic [COUNT_BITS-1:0] len_sat;
  logic [5:0]            cr;

  always_comb begin
    if ({17'd0, item.length} > CNT_MAX) begin
      len_sat = CNT_MAX[COUNT_BITS-1:0];
    end else begin
      len_sat = COUNT_BITS'(item.length);
    end
  end

  assign cr = cur.enables;

  always_comb begin
    nxt         = cur;
    tx_left_nxt = tx_left;
    rx_left_nxt = rx_left;
    res         = '0;
    unique case (item.mode)
      MODE_START_TX: begin
        if (item.length == 16'd0) begin
          res.reply = REPLY_INVALID;
        end else if (!item.status_flags[ST_TC]) begin
          res.reply = REPLY_BUSY;
        end else begin
          nxt.enables[EN_TE]    = 1'b1;
          nxt.enables[EN_TXEIE] = 1'b1;
          nxt.tx_pos            = POS_W'(1);
          tx_left_nxt           = len_sat - COUNT_BITS'(1);
          nxt.tx_phase          = TX_ACTIVE;
          res.dr_write          = 1'b1;
          res.dr_write_data     = item.tx_byte;
        end
      end
      MODE_START_RX: begin
        if (item.length == 16'd0) begin
          res.reply = REPLY_INVALID;
        end else if (item.status_flags[ST_RXNE]) begin
          res.reply = REPLY_BUSY;
        end else begin
          nxt.enables[EN_RXNEIE] = 1'b1;
          nxt.enables[EN_RE]     = 1'b1;
          nxt.rx_pos             = '0;
          rx_left_nxt            = len_sat;
          nxt.rx_phase           = RX_ACTIVE;
        end
      end
      MODE_EVENT: begin
        if (item.status_flags[ST_TXE] && cr[EN_TXEIE] && nxt.tx_phase == TX_ACTIVE) begin
          if (tx_left_nxt != '0) begin
            nxt.enables[EN_TCIE] = 1'b0;
            res.dr_write         = 1'b1;
            res.dr_write_data    = item.tx_byte;
            nxt.tx_pos           = nxt.tx_pos + POS_W'(1);
            tx_left_nxt          = tx_left_nxt - COUNT_BITS'(1);
          end else begin
            nxt.enables[EN_TXEIE] = 1'b0;
            nxt.enables[EN_TCIE]  = 1'b1;
            nxt.tx_phase          = TX_DONE;
          end
        end
        if (item.status_flags[ST_TC] && cr[EN_TCIE] && nxt.tx_phase == TX_DONE) begin
          nxt.enables[EN_TCIE]  = 1'b0;
          nxt.enables[EN_TXEIE] = 1'b0;
          nxt.enables[EN_TE]    = 1'b0;
        end
        if (item.status_flags[ST_RXNE] && cr[EN_RXNEIE] && nxt.rx_phase == RX_ACTIVE) begin
          nxt.enables[EN_IDLEIE] = 1'b1;
          res.rx_store           = 1'b1;
          res.rx_store_data      = item.rx_byte;
          res.rx_store_offset    = nxt.rx_pos;
          nxt.rx_pos             = nxt.rx_pos + POS_W'(1);
          rx_left_nxt            = rx_left_nxt - COUNT_BITS'(1);
          if (rx_left_nxt == '0) begin
            nxt.enables[EN_RE]     = 1'b0;
            nxt.enables[EN_IDLEIE] = 1'b0;
            nxt.rx_phase           = RX_DONE;
          end
        end
        if (item.status_flags[ST_IDLE] && cr[EN_IDLEIE] && nxt.rx_phase == RX_ACTIVE) begin
          nxt.enables[EN_RE]        = 1'b0;
          nxt.enables[EN_IDLEIE]    = 1'b0;
          nxt.rx_phase              = RX_ABORT;
          nxt.sticky[FL_IDLE_ABORT] = 1'b1;
        end
        nxt.sticky[3:0] = nxt.sticky[3:0] | item.status_flags[3:0];
        res.wake        = wake_enable;
      end
      MODE_KILL_TX: begin
        nxt.enables[EN_TCIE]  = 1'b0;
        nxt.enables[EN_TXEIE] = 1'b0;
        nxt.tx_phase          = TX_IDLE;
        tx_left_nxt           = '0;
        nxt.tx_pos            = '0;
      end
      MODE_KILL_RX: begin
        nxt.rx_phase = RX_IDLE;
        rx_left_nxt  = '0;
        nxt.rx_pos   = '0;
      end
      MODE_CLEAR: begin
        nxt.sticky = nxt.sticky & ~item.clear_mask;
      end
      default: begin
      end
    endcase
    res.next_tx_offset = nxt.tx_pos;
    res.tx_status      = tx_code(nxt.tx_phase);
    res.rx_status      = rx_code(nxt.rx_phase);
    res.control_bits   = nxt.enables;
    res.runtime_flags  = nxt.sticky;
  end

endmodule
`default_nettype wire

// ===== tb/sv/uart_interrupt_transfer_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_interrupt_transfer_engine_tb
// streams start, event, kill and clear words into the transfer engine, keeps
// its own copy of the transmit/receive state to predict every result word and
// compares each field; random idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module uart_interrupt_transfer_engine_tb;
  import uite_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_PER_RUN = 330;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  item_t   queued_cmds[$];
  result_t awaited_reports[$];
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  logic    in_taken       = 1'b0;
  logic    hold_armed     = 1'b0;
  logic    hold_started   = 1'b0;
  int      hold_cnt       = 0;
  int      quiet_cycles   = 0;

  // predicted controller state
  logic        wake_en;
  logic [1:0]  tx_ph;
  logic [15:0] tx_left;
  logic [15:0] tx_pos;
  logic [1:0]  rx_ph;
  logic [15:0] rx_left;
  logic [15:0] rx_pos;
  logic [5:0]  ctl_en;
  logic [4:0]  flags;

  uart_interrupt_transfer_engine u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic result_t advance_transfer_state(input item_t cmd);
    result_t    r;
    logic [5:0] en_before;
    logic [7:0] st;
    r = '0;
    st = cmd.status_flags;
    case (cmd.mode)
      MODE_START_TX: begin
        if (cmd.length == 16'd0) begin
          r.reply = REPLY_INVALID;
        end else if (!st[ST_TC]) begin
          r.reply = REPLY_BUSY;
        end else begin
          ctl_en[EN_TE] = 1'b1;
          ctl_en[EN_TXEIE] = 1'b1;
          tx_pos = 16'd1;
          tx_left = cmd.length - 16'd1;
          tx_ph = TXS_ONGOING;
          r.dr_write = 1'b1;
          r.dr_write_data = cmd.tx_byte;
        end
      end
      MODE_START_RX: begin
        if (cmd.length == 16'd0) begin
          r.reply = REPLY_INVALID;
        end else if (st[ST_RXNE]) begin
          r.reply = REPLY_BUSY;
        end else begin
          ctl_en[EN_RXNEIE] = 1'b1;
          ctl_en[EN_RE] = 1'b1;
          rx_pos = 16'd0;
          rx_left = cmd.length;
          rx_ph = RXS_ONGOING;
        end
      end
      MODE_EVENT: begin
        // handlers gate on the enables from before the word
        en_before = ctl_en;
        if (st[ST_TXE] && en_before[EN_TXEIE] && tx_ph == TXS_ONGOING) begin
          if (tx_left != 16'd0) begin
            ctl_en[EN_TCIE] = 1'b0;
            r.dr_write = 1'b1;
            r.dr_write_data = cmd.tx_byte;
            tx_pos = tx_pos + 16'd1;
            tx_left = tx_left - 16'd1;
          end else begin
            ctl_en[EN_TXEIE] = 1'b0;
            ctl_en[EN_TCIE] = 1'b1;
            tx_ph = TXS_COMPLETE;
          end
        end
        if (st[ST_TC] && en_before[EN_TCIE] && tx_ph == TXS_COMPLETE) begin
          ctl_en[EN_TCIE] = 1'b0;
          ctl_en[EN_TXEIE] = 1'b0;
          ctl_en[EN_TE] = 1'b0;
        end
        if (st[ST_RXNE] && en_before[EN_RXNEIE] && rx_ph == RXS_ONGOING) begin
          ctl_en[EN_IDLEIE] = 1'b1;
          r.rx_store = 1'b1;
          r.rx_store_data = cmd.rx_byte;
          r.rx_store_offset = rx_pos;
          rx_pos = rx_pos + 16'd1;
          rx_left = rx_left - 16'd1;
          if (rx_left == 16'd0) begin
            ctl_en[EN_RE] = 1'b0;
            ctl_en[EN_IDLEIE] = 1'b0;
            rx_ph = RXS_COMPLETE;
          end
        end
        if (st[ST_IDLE] && en_before[EN_IDLEIE] && rx_ph == RXS_ONGOING) begin
          ctl_en[EN_RE] = 1'b0;
          ctl_en[EN_IDLEIE] = 1'b0;
          rx_ph = RXS_ABORTED;
          flags[FL_IDLE_ABORT] = 1'b1;
        end
        flags[3:0] = flags[3:0] | st[3:0];
        r.wake = wake_en;
      end
      MODE_KILL_TX: begin
        ctl_en[EN_TCIE] = 1'b0;
        ctl_en[EN_TXEIE] = 1'b0;
        tx_ph = TXS_IDLE;
        tx_left = 16'd0;
        tx_pos = 16'd0;
      end
      MODE_KILL_RX: begin
        // receiver enables stay set
        rx_ph = RXS_IDLE;
        rx_left = 16'd0;
        rx_pos = 16'd0;
      end
      MODE_CLEAR: begin
        flags = flags & ~cmd.clear_mask;
      end
      default: begin
      end
    endcase
    r.next_tx_offset = tx_pos;
    r.tx_status = tx_ph;
    r.rx_status = rx_ph;
    r.control_bits = ctl_en;
    r.runtime_flags = flags;
    return r;
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) begin
      return 16'd0;
    end else if (p < 25) begin
      return 16'($urandom_range(65535));
    end
    return 16'($urandom_range(6, 1));
  endfunction

  function automatic item_t random_cmd();
    item_t       c;
    int unsigned p;
    c.mode = MODE_EVENT;
    c.status_flags = 8'($urandom_range(255));
    c.length = 16'($urandom_range(65535));
    c.tx_byte = 9'($urandom_range(511));
    c.rx_byte = 9'($urandom_range(511));
    c.clear_mask = 5'($urandom_range(31));
    p = $urandom_range(99);
    if (p < 15) begin
      c.mode = MODE_START_TX;
      c.length = pick_length();
      c.status_flags[ST_TC] = ($urandom_range(9) != 0);
    end else if (p < 30) begin
      c.mode = MODE_START_RX;
      c.length = pick_length();
      c.status_flags[ST_RXNE] = ($urandom_range(9) == 0);
    end else if (p < 80) begin
      c.status_flags[3:0] = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd0;
      c.status_flags[ST_IDLE] = ($urandom_range(6) == 0);
      c.status_flags[ST_RXNE] = ($urandom_range(9) < 6);
      c.status_flags[ST_TC] = ($urandom_range(9) < 4);
      c.status_flags[ST_TXE] = ($urandom_range(9) < 7);
    end else if (p < 85) begin
      c.mode = MODE_KILL_TX;
    end else if (p < 90) begin
      c.mode = MODE_KILL_RX;
    end else if (p < 95) begin
      c.mode = MODE_CLEAR;
    end else begin
      c.mode = 3'($urandom_range(7));
    end
    return c;
  endfunction

  task automatic queue_cmd(input logic [2:0] mode, input logic [7:0] st,
                           input logic [15:0] len, input logic [8:0] txb,
                           input logic [8:0] rxb, input logic [4:0] cm);
    item_t c;
    c.mode = mode;
    c.status_flags = st;
    c.length = len;
    c.tx_byte = txb;
    c.rx_byte = rxb;
    c.clear_mask = cm;
    queued_cmds.push_back(c);
  endtask

  task automatic write_wake_enable(input logic v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_WAKE_ENABLE;
    cfg_pwdata <= {{(CFG_DATA_W-1){1'b0}}, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    wake_en = v;
  endtask

  task automatic wait_drained();
    while (queued_cmds.size() != 0 || in_tvalid || awaited_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= {{(IN_DATA_W-$bits(item_t)){1'b0}}, queued_cmds.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_armed && !hold_started) begin
        hold_started <= 1'b1;
        hold_cnt <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected word expected none actual %0h", $time, got);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("reply", want.reply, got.reply);
          check_field("dr_write", want.dr_write, got.dr_write);
          check_field("dr_write_data", want.dr_write_data, got.dr_write_data);
          check_field("rx_store", want.rx_store, got.rx_store);
          check_field("rx_store_data", want.rx_store_data, got.rx_store_data);
          check_field("rx_store_offset", want.rx_store_offset, got.rx_store_offset);
          check_field("next_tx_offset", want.next_tx_offset, got.next_tx_offset);
          check_field("tx_status", want.tx_status, got.tx_status);
          check_field("rx_status", want.rx_status, got.rx_status);
          check_field("control_bits", want.control_bits, got.control_bits);
          check_field("runtime_flags", want.runtime_flags, got.runtime_flags);
          check_field("wake", want.wake, got.wake);
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_reports.push_back(
          advance_transfer_state(item_t'(in_tdata[$bits(item_t)-1:0])));
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wake_en = 1'b0;
    tx_ph = TXS_IDLE;
    tx_left = '0;
    tx_pos = '0;
    rx_ph = RXS_IDLE;
    rx_left = '0;
    rx_pos = '0;
    ctl_en = '0;
    flags = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_wake_enable(1'b1);
    send_idle_pct = 12;
    recv_idle_pct = 73;
    queue_cmd(MODE_START_TX, 8'hFF, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_START_TX, 8'h00, 16'd5, 9'h1FF, 9'h000, 5'h00);
    queue_cmd(MODE_START_RX, 8'h20, 16'd3, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_START_RX, 8'h00, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_START_TX, 8'h40, 16'hFFFF, 9'h1FF, 9'h000, 5'h00);
    queue_cmd(MODE_EVENT, 8'h80, 16'd0, 9'h155, 9'h0AA, 5'h00);
    queue_cmd(MODE_KILL_TX, 8'h00, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_START_TX, 8'h40, 16'd1, 9'h0AA, 9'h000, 5'h00);
    queue_cmd(MODE_EVENT, 8'h80, 16'd0, 9'h033, 9'h000, 5'h00);
    queue_cmd(MODE_EVENT, 8'h40, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_START_RX, 8'hDF, 16'd2, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_EVENT, 8'h20, 16'd0, 9'h000, 9'h1FF, 5'h00);
    queue_cmd(MODE_EVENT, 8'h30, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_START_RX, 8'h00, 16'd4, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_EVENT, 8'h20, 16'd0, 9'h000, 9'h0F0, 5'h00);
    queue_cmd(MODE_EVENT, 8'h10, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_EVENT, 8'h0F, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_CLEAR, 8'h00, 16'd0, 9'h000, 9'h000, 5'h0A);
    queue_cmd(MODE_CLEAR, 8'hFF, 16'hFFFF, 9'h1FF, 9'h1FF, 5'h1F);
    queue_cmd(MODE_START_RX, 8'h00, 16'hFFFF, 9'h000, 9'h000, 5'h00);
    queue_cmd(MODE_KILL_RX, 8'h00, 16'd0, 9'h000, 9'h000, 5'h00);
    queue_cmd(3'd6, 8'hFF, 16'hFFFF, 9'h1FF, 9'h1FF, 5'h1F);
    queue_cmd(3'd7, 8'h0F, 16'h1234, 9'h0AA, 9'h155, 5'h15);
    queue_cmd(MODE_EVENT, 8'hFF, 16'd0, 9'h000, 9'h1FF, 5'h00);
    queue_cmd(MODE_START_TX, 8'hFF, 16'h8000, 9'h100, 9'h000, 5'h00);
    repeat (RANDOM_PER_RUN) queued_cmds.push_back(random_cmd());
    wait_drained();

    write_wake_enable(1'b0);
    send_idle_pct = 73;
    recv_idle_pct = 12;
    repeat (RANDOM_PER_RUN) queued_cmds.push_back(random_cmd());
    wait_drained();

    write_wake_enable(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_RUN) queued_cmds.push_back(random_cmd());
    @(posedge clk);
    hold_armed = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/uite_pkg.sv
design/uite_cfg.sv
design/uite_step.sv
design/uart_interrupt_transfer_engine.sv
tb/sv/uart_interrupt_transfer_engine_tb.sv
